// ===== src/cdcs_pkg.sv =====
// Shared types and constants of the coil driver channel sequencer.
package cdcs_pkg;

	localparam int LimitWidth  = 16;
	localparam int CfgIdxWidth = 4;

	localparam logic [LimitWidth-1:0] InitResReset = 16'd10;
	localparam logic [LimitWidth-1:0] InitRegReset = 16'd100;
	localparam logic [LimitWidth-1:0] TermRegReset = 16'd1000;
	localparam logic [LimitWidth-1:0] TermResReset = 16'd300;

	typedef enum logic [2:0] {
		ST_READY    = 3'd0,
		ST_BUCK     = 3'd1,
		ST_INIT_RES = 3'd2,
		ST_RUN_RES  = 3'd3,
		ST_INIT_REG = 3'd4,
		ST_RUN_REG  = 3'd5,
		ST_TERM_REG = 3'd6,
		ST_TERM_RES = 3'd7
	} mode_t;

	typedef enum logic [CfgIdxWidth-1:0] {
		CFG_INIT_RES = 4'd0,
		CFG_INIT_REG = 4'd1,
		CFG_TERM_REG = 4'd2,
		CFG_TERM_RES = 4'd3
	} cfg_idx_t;

	typedef struct packed {
		logic req_enable_buck;
		logic req_run_resonant;
		logic req_run_regular;
		logic req_stop;
	} req_t;

	typedef struct packed {
		logic [2:0] state_code;
		logic       buck_enable;
		logic       bridge_enable;
		logic       resonant_enable;
		logic       bridge_half_duty;
		logic       clear_setpoints;
		logic       reset_filter;
		logic       reset_controllers;
		logic       configure_bridge;
		logic       restore_default_frequency;
	} res_t;

	typedef struct packed {
		logic [LimitWidth-1:0] res_init;
		logic [LimitWidth-1:0] reg_init;
		logic [LimitWidth-1:0] term_reg;
		logic [LimitWidth-1:0] term_res;
	} limits_t;

endpackage

// ===== src/cdcs_if.sv =====
// Handshake channels of the sequencer: request items, result items, config writes.
interface cdcs_req_if import cdcs_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cdcs_res_if import cdcs_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cdcs_cfg_if import cdcs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CfgIdxWidth-1:0] index;
	logic [LimitWidth-1:0]  value;
	modport source(output valid, output index, output value, input ready);
	modport sink(input valid, input index, input value, output ready);
endinterface

// ===== src/coil_driver_channel_sequencer_unit.sv =====
// Top level of the coil driver channel sequencer.
//
// One request item per control tick; the block answers each with one result
// item carrying the state code after the tick, the buck, bridge and resonant
// line levels and one-tick action pulses. Throughput is one item per clock
// unless res stalls; the state registers and the next-state logic sit in
// front of a single result register, and req.ready stays high as long as the
// result register is empty or is being emptied in the same cycle. The four
// dwell limits reset to 10, 100, 1000 and 300 ticks and are written through
// the cfg channel (always ready, index 0..3, other indexes ignored); a write
// is seen by the next item. The dwell counter is COUNT_WIDTH bits and
// saturates; a timed state whose limit the counter cannot reach is left once
// the counter is full. In buck enabled stop beats run resonant, which beats
// run regular; ready acts only on enable buck and the run states only on stop.
module coil_driver_channel_sequencer_unit import cdcs_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	cdcs_req_if.sink   req,
	cdcs_res_if.source res,
	cdcs_cfg_if.sink   cfg
);

	limits_t limits;
	res_t    step_res;
	logic    step;

	assign cfg.ready = 1'b1;

	cdcs_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_value (cfg.value),
		.limits   (limits)
	);

	// state advances only on an accepted item
	assign step = req.valid && req.ready;

	cdcs_seq_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_seq_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.req    (req.data),
		.limits (limits),
		.res    (step_res)
	);

	cdcs_result_reg u_result_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (step),
		.load_data  (step_res),
		.load_ready (req.ready),
		.out_valid  (res.valid),
		.out_ready  (res.ready),
		.out_data   (res.data)
	);

endmodule

// ===== src/cdcs_cfg_regs.sv =====
// Dwell limit registers written through the config channel.
module cdcs_cfg_regs import cdcs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CfgIdxWidth-1:0] wr_index,
	input  logic [LimitWidth-1:0]  wr_value,
	output limits_t                limits
);

	limits_t limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.res_init <= InitResReset;
			limits_q.reg_init <= InitRegReset;
			limits_q.term_reg <= TermRegReset;
			limits_q.term_res <= TermResReset;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_INIT_RES: limits_q.res_init <= wr_value;
				CFG_INIT_REG: limits_q.reg_init <= wr_value;
				CFG_TERM_REG: limits_q.term_reg <= wr_value;
				CFG_TERM_RES: limits_q.term_res <= wr_value;
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	assign limits = limits_q;

endmodule

// ===== src/cdcs_seq_core.sv =====
// Channel state machine: mode, dwell counter and enable line levels.
module cdcs_seq_core import cdcs_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  req_t    req,
	input  limits_t limits,
	output res_t    res
);

	localparam int CmpWidth = (COUNT_WIDTH > LimitWidth) ? COUNT_WIDTH : LimitWidth;

	mode_t                  mode_q, mode_d;
	logic [COUNT_WIDTH-1:0] dwell_q, dwell_d;
	logic                   buck_q, buck_d;
	logic                   bridge_q, bridge_d;
	logic                   reson_q, reson_d;

	logic [LimitWidth-1:0] cur_limit;
	logic                  waiting;
	logic                  to_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ST_READY;
			dwell_q  <= '0;
			buck_q   <= 1'b0;
			bridge_q <= 1'b0;
			reson_q  <= 1'b0;
		end else if (step) begin
			mode_q   <= mode_d;
			dwell_q  <= dwell_d;
			buck_q   <= buck_d;
			bridge_q <= bridge_d;
			reson_q  <= reson_d;
		end
	end

	// limit of the current timed state; don't care elsewhere
	always_comb begin
		case (mode_q)
			ST_INIT_RES: cur_limit = limits.res_init;
			ST_INIT_REG: cur_limit = limits.reg_init;
			ST_TERM_REG: cur_limit = limits.term_reg;
			default:     cur_limit = limits.term_res;
		endcase
	end

	// stay while below limit and counter not saturated
	assign waiting = (CmpWidth'(dwell_q) < CmpWidth'(cur_limit)) && !(&dwell_q);

	always_comb begin
		mode_d   = mode_q;
		dwell_d  = dwell_q;
		buck_d   = buck_q;
		bridge_d = bridge_q;
		reson_d  = reson_q;
		to_ready = 1'b0;
		res      = '0;

		unique case (mode_q)
			ST_READY: begin
				if (req.req_enable_buck) begin
					buck_d           = 1'b1;
					bridge_d         = 1'b0;
					res.reset_filter = 1'b1;
					mode_d           = ST_BUCK;
				end
			end
			ST_BUCK: begin
				if (req.req_stop) begin
					to_ready = 1'b1;
				end else if (req.req_run_resonant) begin
					dwell_d  = '0;
					buck_d   = 1'b1;
					bridge_d = 1'b0;
					mode_d   = ST_INIT_RES;
				end else if (req.req_run_regular) begin
					dwell_d = '0;
					reson_d = 1'b1;
					mode_d  = ST_INIT_REG;
				end
			end
			ST_INIT_RES: begin
				if (waiting) begin
					dwell_d = dwell_q + 1'b1;
				end else begin
					reson_d               = 1'b1;
					buck_d                = 1'b1;
					bridge_d              = 1'b1;
					res.configure_bridge  = 1'b1;
					res.reset_controllers = 1'b1;
					mode_d                = ST_RUN_RES;
				end
			end
			ST_RUN_RES: begin
				if (req.req_stop) begin
					res.bridge_half_duty = 1'b1;
					dwell_d              = '0;
					mode_d               = ST_TERM_RES;
				end
			end
			ST_INIT_REG: begin
				if (waiting) begin
					dwell_d = dwell_q + 1'b1;
				end else begin
					bridge_d             = 1'b1;
					res.configure_bridge = 1'b1;
					mode_d               = ST_RUN_REG;
				end
			end
			ST_RUN_REG: begin
				if (req.req_stop) begin
					bridge_d = 1'b0;
					dwell_d  = '0;
					mode_d   = ST_TERM_REG;
				end
			end
			ST_TERM_REG: begin
				if (waiting) begin
					dwell_d = dwell_q + 1'b1;
				end else begin
					reson_d                       = 1'b0;
					res.restore_default_frequency = 1'b1;
					to_ready                      = 1'b1;
				end
			end
			ST_TERM_RES: begin
				// resonant line stays as is
				if (waiting) begin
					dwell_d = dwell_q + 1'b1;
				end else begin
					bridge_d = 1'b0;
					to_ready = 1'b1;
				end
			end
			default: ;
		endcase

		if (to_ready) begin
			buck_d              = 1'b0;
			bridge_d            = 1'b0;
			res.clear_setpoints = 1'b1;
			mode_d              = ST_READY;
		end

		res.state_code      = mode_d;
		res.buck_enable     = buck_d;
		res.bridge_enable   = bridge_d;
		res.resonant_enable = reson_d;
	end

endmodule

// ===== src/cdcs_result_reg.sv =====
// Result register; lets the next item in while the current result is taken.
module cdcs_result_reg import cdcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t load_data,
	output logic load_ready,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);

	logic valid_q;
	res_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign load_ready = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_data   = data_q;

endmodule
